// ----- hdl/tile_map_box_collision_defines.svh -----
// Assertion helpers shared by the tile map collision RTL.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef TILE_MAP_BOX_COLLISION_DEFINES_SVH
`define TILE_MAP_BOX_COLLISION_DEFINES_SVH

// Same-cycle implication, checked only out of reset
`define TMBC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset
`define TMBC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/tmbc_pkg.sv -----
`timescale 1ns / 1ps

package tmbc_pkg;

    // Field widths fixed by the item format
    localparam int COL_W = 6;
    localparam int ROW_W = 5;
    localparam int POS_W = 15;
    localparam int VEL_W = 11;
    localparam int BOX_W = 8;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;

    // Configuration reset values
    localparam logic [BOX_W-1:0] BOX_WIDTH_RST  = 8'd32;
    localparam logic [BOX_W-1:0] BOX_HEIGHT_RST = 8'd48;

    // Classified command handed from front to back
    typedef struct packed {
        logic             query;   // 1 for a collision query
        logic             wr_en;   // write lands inside the grid
        logic             solid;   // bit to write
        logic [COL_W-1:0] col;     // write column
        logic [ROW_W-1:0] row;     // write row
        logic             span_ok; // some tile can touch the box
        logic [COL_W-1:0] xlo;     // first candidate column
        logic [COL_W-1:0] xhi;     // last candidate column
        logic [ROW_W-1:0] ylo;     // first candidate row
        logic [ROW_W-1:0] yhi;     // last candidate row
    } tmbc_cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } tmbc_bstate_t;

endpackage

// ----- hdl/tmbc_ram.sv -----
`timescale 1ns / 1ps

module tmbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tmbc_front.sv -----
`timescale 1ns / 1ps

module tmbc_front import tmbc_pkg::*; #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [COL_W-1:0]        tile_col,
    input  logic [ROW_W-1:0]        tile_row,
    input  logic                    tile_solid,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [VEL_W-1:0] vel_x,
    input  logic signed [VEL_W-1:0] vel_y,
    input  logic [BOX_W-1:0]        box_width,
    input  logic [BOX_W-1:0]        box_height,
    output logic                    q_push,
    input  logic                    q_ready,
    output tmbc_cmd_t               q_cmd
);

    localparam logic signed [9:0] XMAX = 10'(GRID_COLS - 1);
    localparam logic signed [9:0] YMAX = 10'(GRID_ROWS - 1);

    typedef struct packed {
        logic             ok;
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
    } span_t;

    // Tiles whose near or far edge falls in [p, p + len*16] (12.4 units).
    // Edge k sits at k*256; edges from ceil(p/256) to floor((p+len*16)/256)
    // touch the span, and tiles k-1 and k share edge k.
    function automatic span_t tile_span(input logic signed [15:0] p,
                                        input logic [BOX_W-1:0] len,
                                        input logic signed [9:0] lim);
        logic signed [16:0] p_ceil;
        logic signed [16:0] p_end;
        logic signed [9:0]  kmin;
        logic signed [9:0]  kmin1;
        logic signed [9:0]  kmax;
        logic signed [9:0]  lo;
        logic signed [9:0]  hi;
        span_t              s;
        p_ceil = {p[15], p} + 17'sd255;
        p_end  = {p[15], p} + $signed({5'd0, len, 4'd0});
        kmin   = 10'(p_ceil >>> 8);
        kmax   = 10'(p_end >>> 8);
        kmin1  = kmin - 10'sd1;
        lo     = (kmin1 < 10'sd0) ? 10'sd0 : kmin1;
        hi     = (kmax > lim) ? lim : kmax;
        s.ok   = (kmin <= kmax) && (kmax >= 10'sd0) && (kmin1 <= lim);
        s.lo   = lo[COL_W-1:0];
        s.hi   = hi[COL_W-1:0];
        return s;
    endfunction

    logic                    f_valid_reg;
    logic                    f_valid_next;
    logic                    f_query_reg;
    logic [COL_W-1:0]        f_col_reg;
    logic [ROW_W-1:0]        f_row_reg;
    logic                    f_solid_reg;
    logic signed [15:0]      f_px_reg;
    logic signed [15:0]      f_py_reg;
    logic                    take;
    span_t                   xs;
    span_t                   ys;

    // Accept when the staging register is empty or draining
    assign in_ready     = !f_valid_reg || q_ready;
    assign take         = in_valid && in_ready;
    assign q_push       = f_valid_reg && q_ready;
    assign f_valid_next = take ? 1'b1 : (q_push ? 1'b0 : f_valid_reg);

    // Staging valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    // Capture the item and move the box
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_query_reg <= (op == OP_QUERY);
            f_col_reg   <= tile_col;
            f_row_reg   <= tile_row;
            f_solid_reg <= tile_solid;
            f_px_reg    <= 16'(pos_x) + 16'(vel_x);
            f_py_reg    <= 16'(pos_y) + 16'(vel_y);
        end
    end

    // Classify: candidate column and row ranges, or write target
    always_comb
    begin
        xs            = tile_span(f_px_reg, box_width, XMAX);
        ys            = tile_span(f_py_reg, box_height, YMAX);
        q_cmd.query   = f_query_reg;
        q_cmd.wr_en   = ({1'b0, f_col_reg} < 7'(GRID_COLS))
                        && ({1'b0, f_row_reg} < 6'(GRID_ROWS));
        q_cmd.solid   = f_solid_reg;
        q_cmd.col     = f_col_reg;
        q_cmd.row     = f_row_reg;
        q_cmd.span_ok = xs.ok && ys.ok;
        q_cmd.xlo     = xs.lo;
        q_cmd.xhi     = xs.hi;
        q_cmd.ylo     = ys.lo[ROW_W-1:0];
        q_cmd.yhi     = ys.hi[ROW_W-1:0];
    end

endmodule

// ----- hdl/tmbc_queue.sv -----
`timescale 1ns / 1ps

`include "tile_map_box_collision_defines.svh"

module tmbc_queue import tmbc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      push_ready,
    input  tmbc_cmd_t push_cmd,
    input  logic      pop,
    output logic      pop_valid,
    output tmbc_cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tmbc_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TMBC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

// ----- hdl/tmbc_back.sv -----
`timescale 1ns / 1ps

`include "tile_map_box_collision_defines.svh"

module tmbc_back import tmbc_pkg::*; #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  tmbc_cmd_t        q_cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_hit,
    output logic [9:0]       out_block_x,
    output logic [8:0]       out_block_y
);

    localparam int CA_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RA_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    tmbc_bstate_t         state_reg;
    tmbc_bstate_t         state_next;
    tmbc_cmd_t            cmd_reg;
    logic [COL_W-1:0]     cur_reg;
    logic [COL_W-1:0]     cur_next;
    logic [GRID_COLS-1:0] valid_reg;
    logic                 res_hit_reg;
    logic [COL_W-1:0]     res_col_reg;
    logic [ROW_W-1:0]     res_row_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [9:0]           out_bx_reg;
    logic [8:0]           out_by_reg;

    logic                 rd_en;
    logic [CA_W-1:0]      rd_addr;
    logic [GRID_ROWS-1:0] rd_data;
    logic                 wr_en;
    logic [GRID_ROWS-1:0] wr_data;
    logic [GRID_ROWS-1:0] word;
    logic [GRID_ROWS-1:0] ymask;
    logic [GRID_ROWS-1:0] hits;
    logic                 found;
    logic [ROW_W-1:0]     found_row;
    logic                 last_col;
    logic                 out_free;
    logic                 scan_step;
    logic                 load_res;
    logic                 clear_res;
    logic                 load_out;

    tmbc_ram #(
        .WIDTH (GRID_ROWS),
        .DEPTH (GRID_COLS)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cmd_reg.col[CA_W-1:0]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Column word as read; a never-written column reads clear
    always_comb
    begin
        word = valid_reg[cur_reg[CA_W-1:0]] ? rd_data : '0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            ymask[r] = (ROW_W'(r) >= cmd_reg.ylo) && (ROW_W'(r) <= cmd_reg.yhi);
        end
        hits = word & ymask;
        wr_data = word;
        wr_data[cmd_reg.row[RA_W-1:0]] = cmd_reg.solid;
    end

    // Pick the lowest solid row in the column
    always_comb
    begin
        found_row = '0;
        for (int r = GRID_ROWS - 1; r >= 0; r--)
        begin
            if (hits[r])
            begin
                found_row = ROW_W'(r);
            end
        end
        found = |hits;
    end

    assign last_col = (cur_reg == cmd_reg.xhi);
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if ((q_cmd.query && q_cmd.span_ok) || (!q_cmd.query && q_cmd.wr_en))
                    begin
                        state_next = B_SCAN;
                    end
                    else
                    begin
                        state_next = B_DONE;
                    end
                end
            end
            B_SCAN:
            begin
                if (!cmd_reg.query || found || last_col)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cmd_reg.xlo[CA_W-1:0];
        wr_en     = 1'b0;
        scan_step = 1'b0;
        load_res  = 1'b0;
        clear_res = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop     = q_valid;
                rd_en     = q_valid;
                rd_addr   = q_cmd.query ? q_cmd.xlo[CA_W-1:0] : q_cmd.col[CA_W-1:0];
                clear_res = q_valid;
            end
            B_SCAN:
            begin
                wr_en    = !cmd_reg.query;
                load_res = cmd_reg.query;
                if (cmd_reg.query && !found && !last_col)
                begin
                    scan_step = 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = CA_W'(cur_reg + 1'b1);
                end
            end
            B_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign cur_next = q_pop ? (q_cmd.query ? q_cmd.xlo : q_cmd.col)
                      : (scan_step ? COL_W'(cur_reg + 1'b1) : cur_reg);

    // Control state, written-column marks and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                valid_reg[cmd_reg.col[CA_W-1:0]] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command, scan position, result and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        cur_reg <= cur_next;
        if (clear_res)
        begin
            res_hit_reg <= 1'b0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end
        else if (load_res)
        begin
            res_hit_reg <= found;
            res_col_reg <= found ? cur_reg : '0;
            res_row_reg <= found ? found_row : '0;
        end
        if (load_out)
        begin
            out_hit_reg <= res_hit_reg;
            out_bx_reg  <= {res_col_reg, 4'd0};
            out_by_reg  <= {res_row_reg, 4'd0};
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_hit     = out_hit_reg;
    assign out_block_x = out_bx_reg;
    assign out_block_y = out_by_reg;

    `TMBC_ASSERT_NOW(a_scan_in_range, (state_reg == B_SCAN) && cmd_reg.query, cur_reg <= cmd_reg.xhi, "scan ran past last column")
    `TMBC_ASSERT_NEXT(a_write_one_step, (state_reg == B_SCAN) && !cmd_reg.query, state_reg == B_DONE, "write took more than one step")
    `TMBC_ASSERT_NOW(a_write_no_hit, (state_reg == B_DONE) && !cmd_reg.query, !res_hit_reg, "write reported a hit")

endmodule

// ----- hdl/tile_map_box_collision.sv -----
`timescale 1ns / 1ps

// Tile map box collision.
// Input stream (s_*): one item per handshake. tuser selects the kind: a write
// sets or clears one tile's solid bit, a query moves a box by its velocity and
// looks for the first solid tile (column by column, row by row) that touches it.
// Output stream (m_*): exactly one item per input item, in order; hit in tuser,
// hit tile corner in tdata (all zero for writes and misses).
// Config channel (cfg_*): always ready; index 0 is box width, 1 box height,
// other indexes are dropped. Write it only while the block is idle.
// A query searches at most 17 tile columns with a 255-pixel box and searches
// none when the box misses the grid. The back end handles one item at a time,
// reading one column word of the map per cycle while it searches; a two-entry
// queue and an input staging register let up to three more items be taken
// while it works.
// Reset: map reads all clear at once (one mark per column word), box size
// returns to 32 x 48. If m_tready stays low the result waits in the output
// register and the queue fills before s_tready drops.
module tile_map_box_collision import tmbc_pkg::*; #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tile_col[5:0], tile_row[10:6], tile_solid[11], pos_x[26:12],
    // pos_y[41:27], vel_x[52:42], vel_y[63:53]
    input  logic [63:0]          s_tdata,
    // op[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // block_x[9:0], block_y[18:10], zero[23:19]
    output logic [23:0]          m_tdata,
    // hit[0]
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BOX_W-1:0]     cfg_data
);

    logic [BOX_W-1:0] box_width_reg;
    logic [BOX_W-1:0] box_height_reg;
    logic             q_push;
    logic             q_push_ready;
    tmbc_cmd_t        q_push_cmd;
    logic             q_pop;
    logic             q_pop_valid;
    tmbc_cmd_t        q_pop_cmd;
    logic [9:0]       block_x;
    logic [8:0]       block_y;

    assign cfg_ready = 1'b1;

    // Box size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg  <= BOX_WIDTH_RST;
            box_height_reg <= BOX_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                REG_BOX_HEIGHT: box_height_reg <= cfg_data;
                default:        box_width_reg  <= box_width_reg;
            endcase
        end
    end

    tmbc_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .tile_col   (s_tdata[5:0]),
        .tile_row   (s_tdata[10:6]),
        .tile_solid (s_tdata[11]),
        .pos_x      ($signed(s_tdata[26:12])),
        .pos_y      ($signed(s_tdata[41:27])),
        .vel_x      ($signed(s_tdata[52:42])),
        .vel_y      ($signed(s_tdata[63:53])),
        .box_width  (box_width_reg),
        .box_height (box_height_reg),
        .q_push     (q_push),
        .q_ready    (q_push_ready),
        .q_cmd      (q_push_cmd)
    );

    tmbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_cmd    (q_pop_cmd)
    );

    tmbc_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_pop_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_pop_cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hit     (m_tuser),
        .out_block_x (block_x),
        .out_block_y (block_y)
    );

    assign m_tdata = {5'd0, block_y, block_x};

endmodule
